// ===== hdl/frf_pkg.sv =====
// frf_pkg: shared constants and command/status types for the record repeat filter
// no dependencies; used by frf_ctrl, frf_datapath, fixed_record_repeat_filter and tb_top
`timescale 1ns / 1ps

package frf_pkg;

  localparam int MAX_RECORD_DEFAULT = 64;
  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] RECORD_LEN_RESET = 7'd16;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_RECORD_LEN = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic cap;     // capture input byte, read previous bank
    logic commit;  // write byte, update flags, decide emission
    logic rd;      // read next stored byte of the emitted record
    logic ld;      // load read byte into output register
  } frf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_go;    // record (or partial) must be replayed
    logic emit_last;  // byte being loaded is the last one
    logic out_busy;   // output register full and not taken this cycle
  } frf_status_t;

endpackage

// ===== hdl/frf_ram.sv =====
// frf_ram: generic simple dual-port ram, one write and one registered read port
// no package dependency
`timescale 1ns / 1ps

module frf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/frf_ctrl.sv =====
// frf_ctrl: controller state machine of the record repeat filter
// depends on frf_pkg for command and status types
`timescale 1ns / 1ps

module frf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frf_pkg::frf_status_t status,
  output frf_pkg::frf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t state;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.cap    = (state == ST_IDLE) && in_valid;
  assign cmd.commit = (state == ST_COMPARE);
  assign cmd.rd     = (state == ST_EMIT_RD) && !status.out_busy;
  assign cmd.ld     = (state == ST_EMIT_LD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_COMPARE;
        end
        ST_COMPARE: begin
          state <= status.emit_go ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          if (!status.out_busy) state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          state <= status.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/frf_datapath.sv =====
// frf_datapath: record store, fill/compare state and output register
// depends on frf_pkg and frf_ram
`timescale 1ns / 1ps

module frf_datapath #(
  parameter int MAX_RECORD = frf_pkg::MAX_RECORD_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  frf_pkg::frf_cmd_t          cmd,
  output frf_pkg::frf_status_t       status,
  input  logic [frf_pkg::LEN_W-1:0]  record_len,
  input  logic [frf_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_eos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [frf_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);

  localparam int PW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam int CW = $clog2(MAX_RECORD + 1);
  localparam int DEPTH = 2 * MAX_RECORD;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] BANK_OFS = AW'(MAX_RECORD);
  localparam logic [frf_pkg::LEN_W-1:0] LEN_MAX = frf_pkg::LEN_W'(MAX_RECORD);

  logic [frf_pkg::BYTE_W-1:0] byte_reg;
  logic                       eos_reg;
  logic [PW-1:0]              pos;
  logic                       bank;
  logic                       have_prev;
  logic                       differs;
  logic                       emit_bank;
  logic [CW-1:0]              emit_count;
  logic [PW-1:0]              k;

  logic [CW-1:0]              len_eff;
  logic [CW-1:0]              count;
  logic                       complete;
  logic                       differs_new;
  logic                       emit_go;
  logic [AW-1:0]              cmp_addr;
  logic [AW-1:0]              cur_addr;
  logic [AW-1:0]              emit_addr;
  logic [AW-1:0]              raddr;
  logic [frf_pkg::BYTE_W-1:0] rdata;

  // zero acts as one, anything above the store size as the store size
  always_comb begin
    if (record_len == '0) begin
      len_eff = CW'(1);
    end else if (record_len > LEN_MAX) begin
      len_eff = CW'(MAX_RECORD);
    end else begin
      len_eff = record_len[CW-1:0];
    end
  end

  assign count       = CW'(pos) + CW'(1);
  assign complete    = (count >= len_eff);
  assign differs_new = differs || (have_prev && (rdata != byte_reg));
  assign emit_go     = complete ? (!have_prev || differs_new) : eos_reg;

  assign cmp_addr  = bank ? (BANK_OFS + AW'(pos)) : AW'(pos);
  assign cur_addr  = bank ? AW'(pos) : (BANK_OFS + AW'(pos));
  assign emit_addr = emit_bank ? (BANK_OFS + AW'(k)) : AW'(k);
  assign raddr     = cmd.cap ? cmp_addr : emit_addr;

  assign status.emit_go   = emit_go;
  assign status.emit_last = ((CW'(k) + CW'(1)) == emit_count);
  assign status.out_busy  = out_valid && !out_ready;

  frf_ram #(
    .WIDTH(frf_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(cur_addr),
    .wdata(byte_reg),
    .re   (cmd.cap || cmd.rd),
    .raddr(raddr),
    .rdata(rdata)
  );

  // payload captures
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      byte_reg <= in_byte;
      eos_reg  <= in_eos;
    end
    if (cmd.commit) begin
      // cur_addr is the bank opposite cmp_addr, i.e. the current bank
      emit_bank  <= !bank;
      emit_count <= count;
    end
    if (cmd.ld) begin
      out_byte <= rdata;
      out_last <= status.emit_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bank      <= 1'b0;
      have_prev <= 1'b0;
      differs   <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        k <= '0;
        if (eos_reg) begin
          pos       <= '0;
          bank      <= 1'b0;
          have_prev <= 1'b0;
          differs   <= 1'b0;
        end else if (complete) begin
          pos       <= '0;
          bank      <= !bank;
          have_prev <= 1'b1;
          differs   <= 1'b0;
        end else begin
          pos     <= count[PW-1:0];
          differs <= differs_new;
        end
      end
      if (cmd.ld) begin
        k <= k + PW'(1);
      end
      if (cmd.ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/fixed_record_repeat_filter.sv =====
// fixed_record_repeat_filter: top level, apb register and stream glue
// depends on frf_pkg, frf_ctrl, frf_datapath (and frf_ram below it)
`timescale 1ns / 1ps

// usage
//   slave stream: one byte per transfer, tdata[7:0] = data_byte, tlast = end of stream
//   master stream: emitted bytes, tdata[7:0] = out_byte, tlast = last byte for that input
//   apb: register record_len at address 0 (bits 6:0), bytes per record, reset 16
//   bytes are gathered into records of record_len bytes; the first full record of a
//   stream is always sent, later full records only when they differ from the one
//   before; a partial record at end of stream is sent as it is
// input and replay
//   each input byte is captured, then compared and stored against the
//   store's single read port; s_tready is high only while idle
//   a passed record is replayed from the store (ram read, then output register
//   load per byte); s_tready stays low until its last byte is loaded
// reset
//   rst clears fill position, bank select and flags; record_len returns to 16; the
//   record store content is left as is
// stall
//   the output register holds its byte while m_tready is low and replay pauses;
//   the next input byte is taken while the last emitted byte still waits
module fixed_record_repeat_filter #(
  parameter int MAX_RECORD = frf_pkg::MAX_RECORD_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // end_of_stream
  // master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,   // run_last
  // apb configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [frf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [frf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [frf_pkg::LEN_W-1:0] record_len;
  logic                      reg_hit;
  frf_pkg::frf_cmd_t         cmd;
  frf_pkg::frf_status_t      status;

  // register decode: one word register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == frf_pkg::REG_RECORD_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_len <= frf_pkg::RECORD_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      record_len <= pwdata[frf_pkg::LEN_W-1:0];
    end
  end

  // read back, zero beyond the register
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(frf_pkg::APB_DATA_W - frf_pkg::LEN_W){1'b0}}, record_len};
    end
  end

  // sequencer: capture, compare, replay
  frf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // store, fill state and output register
  frf_datapath #(
    .MAX_RECORD(MAX_RECORD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .record_len(record_len),
    .in_byte   (s_tdata),
    .in_eos    (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for fixed_record_repeat_filter, apb setup plus byte streams
// depends on frf_pkg and the rtl under hdl; keeps its own shadow of the record store
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_REC = frf_pkg::MAX_RECORD_DEFAULT;

  // one emitted byte as the master side should deliver it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } replay_byte_t;

  // how the generator fills a record relative to the one before it
  typedef enum {REC_FRESH, REC_REPEAT, REC_ONE_OFF} rec_kind_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // dut ports, all inputs known from time zero
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;   // [7:0] data_byte
  logic                           s_tlast = 1'b0; // end_of_stream
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;        // [7:0] out_byte
  logic                           m_tlast;        // run_last
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [frf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [frf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [frf_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  fixed_record_repeat_filter u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the filter: record store, control state and the length register
  logic [7:0] shadow_store [0:2*MAX_REC-1];
  logic [6:0] fill_pos = '0;
  logic       bank_sel = 1'b0;
  logic       have_prev = 1'b0;
  logic       differs = 1'b0;
  logic [6:0] cfg_len = frf_pkg::RECORD_LEN_RESET;

  // bytes the master side still owes us, oldest first
  replay_byte_t pending_bytes [$];

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned streams_sent = 0;
  int unsigned records_passed = 0;
  int unsigned records_dropped = 0;
  int unsigned len_writes = 0;

  // idling knobs, flipped by the tests
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;

  // long receiver hold-off, requested by the backpressure test
  int unsigned hold_len = 0;
  logic        hold_active = 1'b0;
  int unsigned stall_left = 0;

  function automatic void report_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // record_len as the filter applies it: 0 acts as 1, above MAX_REC clamps
  function automatic int unsigned eff_len();
    int unsigned n;
    n = 32'(cfg_len);
    if (n < 1) n = 1;
    if (n > MAX_REC) n = MAX_REC;
    return n;
  endfunction

  // queue the first count bytes of a bank for replay, last byte flagged
  function automatic void queue_replay(input logic bank, input int unsigned count);
    replay_byte_t item;
    for (int unsigned k = 0; k < count; k++) begin
      item.out_byte = shadow_store[{bank, 6'(k)}];
      item.run_last = (k + 1 == count);
      pending_bytes.push_back(item);
    end
  endfunction

  // advance the shadow filter by one accepted byte
  function automatic void predict_filter(input logic [7:0] b, input logic eos);
    int unsigned len, pos, count;
    logic        cur;
    len = eff_len();
    pos = 32'(fill_pos);
    if (pos >= MAX_REC) pos = MAX_REC - 1;
    cur = bank_sel;
    // running compare against the same position of the previous record
    if (have_prev && shadow_store[{~cur, 6'(pos)}] != b) differs = 1'b1;
    shadow_store[{cur, 6'(pos)}] = b;
    count = pos + 1;
    if (count >= len) begin
      // full record: first of the stream or a changed one goes out
      if (!have_prev || differs) begin
        queue_replay(cur, count);
        records_passed++;
      end else begin
        records_dropped++;
      end
      bank_sel = ~cur;
      have_prev = 1'b1;
      differs = 1'b0;
      fill_pos = '0;
    end else begin
      fill_pos = 7'(count);
      // partial record at end of stream goes out as is
      if (eos) queue_replay(cur, count);
    end
    if (eos) begin
      fill_pos = '0;
      bank_sel = 1'b0;
      have_prev = 1'b0;
      differs = 1'b0;
    end
  endfunction

  // one byte on the slave side; valid stays up across back-to-back transfers
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    predict_filter(b, eos);
    bytes_sent++;
  endtask

  // n bytes, either fresh or built from the previous record held in the shadow store
  task automatic send_record(input int unsigned n, input rec_kind_t kind,
                             input bit eos_at_end);
    int unsigned flip_at;
    logic [7:0]  b;
    flip_at = $urandom_range(0, n - 1);
    for (int unsigned k = 0; k < n; k++) begin
      if (kind == REC_FRESH || !have_prev) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = shadow_store[{~bank_sel, fill_pos[5:0]}];
        if (kind == REC_ONE_OFF && k == flip_at) b = b ^ 8'($urandom_range(1, 255));
      end
      send_byte(b, eos_at_end && (k + 1 == n));
    end
  endtask

  // drop valid, let every owed byte arrive, then give the datapath time to go quiet
  task automatic drain_and_idle();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // apb write of record_len, then read it back
  task automatic set_record_len(input logic [6:0] value);
    drain_and_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {frf_pkg::REG_RECORD_LEN, 2'b00};
    pwdata  <= {{(frf_pkg::APB_DATA_W-frf_pkg::LEN_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_len = value;
    len_writes++;
    // read access right behind the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[frf_pkg::LEN_W-1:0] !== cfg_len)
      report_mismatch($sformatf("record_len read back %0d, wrote %0d",
                                prdata[frf_pkg::LEN_W-1:0], cfg_len));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [6:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 70) return 7'($urandom_range(1, 6));
    if (r < 92) return 7'($urandom_range(7, 16));
    if (r < 97) return 7'($urandom_range(17, 40));
    return 7'($urandom_range(64, 127));
  endfunction

  function automatic rec_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return REC_REPEAT;
    if (r < 70) return REC_ONE_OFF;
    return REC_FRESH;
  endfunction

  // ---------------------------------------------------------------- tests

  // register write and read back at the extremes
  task automatic test_register_access();
    set_record_len(7'd127);
    set_record_len(7'd0);
    set_record_len(7'd64);
    set_record_len(7'd1);
  endtask

  // two-byte records: first passes, exact repeat dropped, changed one passes,
  // partial tail goes out at end of stream
  task automatic test_repeat_drop();
    set_record_len(7'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    streams_sent++;
  endtask

  // length zero behaves as one; stream ends on a full changed record
  task automatic test_len_zero();
    set_record_len(7'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    streams_sent++;
  endtask

  // end of stream on a full repeat emits nothing more
  task automatic test_end_on_full_repeat();
    set_record_len(7'd1);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b1);
    streams_sent++;
  endtask

  // end of stream inside the very first record
  task automatic test_partial_first();
    set_record_len(7'd3);
    send_byte(8'h12, 1'b1);
    streams_sent++;
  endtask

  // length cut below the fill level mid-record: record closes on the next byte
  task automatic test_len_lowered();
    set_record_len(7'd4);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hB2, 1'b0);
    send_byte(8'hC3, 1'b0);
    set_record_len(7'd2);
    send_byte(8'hD4, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hB2, 1'b0);
    send_byte(8'h7E, 1'b1);
    streams_sent++;
  endtask

  // largest records with receiver gaps on; over-range length clamps to 64
  task automatic test_long_records();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b1;
    set_record_len(7'd127);
    send_record(MAX_REC, REC_FRESH, 1'b0);
    send_record(MAX_REC, REC_REPEAT, 1'b1);
    streams_sent++;
    set_record_len(7'd64);
    send_record(MAX_REC, REC_FRESH, 1'b0);
    send_record(5, REC_FRESH, 1'b1);
    streams_sent++;
  endtask

  // receiver holds off while the sender keeps pushing changed records
  task automatic test_output_backpressure();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    set_record_len(7'd6);
    hold_len = 250;
    for (int r = 0; r < 5; r++) send_record(6, REC_FRESH, r == 4);
    streams_sent++;
    drain_and_idle();
  endtask

  // random length cuts in the middle of a record, only ever downward
  task automatic test_shrink_midrecord(input int unsigned rounds);
    int unsigned len, part;
    for (int unsigned i = 0; i < rounds; i++) begin
      src_gaps_on  = 1'($urandom_range(0, 1));
      sink_gaps_on = 1'($urandom_range(0, 1));
      set_record_len(7'($urandom_range(3, 12)));
      len = eff_len();
      send_record(len, REC_FRESH, 1'b0);
      part = $urandom_range(1, len - 1);
      send_record(part, pick_kind(), 1'b0);
      set_record_len(7'($urandom_range(0, part)));
      send_record(1, pick_kind(), 1'b0);
      len = eff_len();
      send_record(len, REC_REPEAT, 1'b0);
      send_record(len, pick_kind(), 1'b1);
      streams_sent++;
    end
  endtask

  // mostly well-formed streams of related records, some raw noise
  task automatic test_random_streams(input int unsigned stop_at);
    int unsigned len, nrec, cnt;
    bit          tail;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) set_record_len(pick_len());
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      len = eff_len();
      if ($urandom_range(0, 6) == 0) begin
        // noise: random bytes, end of stream may land anywhere
        cnt = $urandom_range(1, 2 * len);
        for (int unsigned k = 0; k < cnt; k++)
          send_byte(8'($urandom_range(0, 255)),
                    (k + 1 == cnt) || ($urandom_range(0, 9) == 0));
      end else begin
        nrec = (len > 32) ? 1 : $urandom_range(1, 4);
        tail = (len > 1) && ($urandom_range(0, 9) < 4);
        for (int unsigned r = 0; r < nrec; r++)
          send_record(len, (r == 0) ? REC_FRESH : pick_kind(), !tail && (r + 1 == nrec));
        if (tail) send_record($urandom_range(1, len - 1), pick_kind(), 1'b1);
      end
      streams_sent++;
    end
  endtask

  // ---------------------------------------------------------------- sink side

  // per-transfer random stall, plus the long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && sink_gaps_on) stall_left = $urandom_range(0, 15);
      if (hold_active || stall_left > 0) begin
        m_tready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // long hold-off counted here, independent of the sender
  initial begin
    forever begin
      wait (hold_len > 0);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_active <= 1'b0;
      hold_len = 0;
    end
  end

  // compare each master transfer with the oldest owed byte
  always @(posedge clk) begin
    replay_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.out_byte || m_tlast !== want.run_last)
          report_mismatch($sformatf("byte exp %02h last %0b, got %02h last %0b",
                                    want.out_byte, want.run_last, m_tdata, m_tlast));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_repeat_drop();
    test_len_zero();
    test_end_on_full_repeat();
    test_partial_first();
    test_len_lowered();
    test_long_records();
    test_output_backpressure();
    test_shrink_midrecord(6);
    test_random_streams(460);

    drain_and_idle();
    $display("covered %0d input bytes in %0d streams, %0d output bytes checked",
             bytes_sent, streams_sent, bytes_checked);
    $display("records passed %0d, repeats dropped %0d, record_len writes %0d",
             records_passed, records_dropped, len_writes);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("timeout with %0d output bytes still owed", pending_bytes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
